FILE: hw/rtl/midi_note_staff_speller_macros.svh
// Assertion macros for the staff speller RTL.
// Taken in by `include; no other dependencies.
`ifndef MIDI_NOTE_STAFF_SPELLER_MACROS_SVH
`define MIDI_NOTE_STAFF_SPELLER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define MNSS_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error("staff speller check failed");

// next-cycle implication, checked out of reset
`define MNSS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("staff speller check failed");

`else

`define MNSS_ASSERT_NOW(label, clk, rst_n, cond, prop)
`define MNSS_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

FILE: hw/rtl/mnss_pkg.sv
// Types, constants and lookup functions for the staff speller.
// No dependencies; used by midi_note_staff_speller.
package mnss_pkg;

    localparam int LETTERS = 7;

    localparam logic CMD_NOTE    = 1'b0;
    localparam logic CMD_RESTORE = 1'b1;

    typedef enum logic [1:0] {
        ACC_NATURAL = 2'd0,
        ACC_SHARP   = 2'd1,
        ACC_FLAT    = 2'd2
    } t_acc;

    typedef t_acc [LETTERS-1:0] t_acc_vec;

    typedef struct packed {
        logic       command;
        logic [6:0] note_number;
    } t_in_beat;

    typedef struct packed {
        logic [6:0] staff_note;
        logic       needs_accidental;
    } t_out_beat;

    // order in which sharps / flats enter a key signature
    localparam logic [2:0] SHARP_ORDER [LETTERS] = '{3'd3, 3'd0, 3'd4, 3'd1, 3'd5, 3'd2, 3'd6};
    localparam logic [2:0] FLAT_ORDER  [LETTERS] = '{3'd6, 3'd2, 3'd5, 3'd1, 3'd4, 3'd0, 3'd3};

    function automatic logic [2:0] pc_letter(input logic [3:0] pc);
        logic [2:0] l;
        case (pc)
            4'd0, 4'd1:  l = 3'd0;
            4'd2, 4'd3:  l = 3'd1;
            4'd4:        l = 3'd2;
            4'd5, 4'd6:  l = 3'd3;
            4'd7, 4'd8:  l = 3'd4;
            4'd9, 4'd10: l = 3'd5;
            default:     l = 3'd6;
        endcase
        return l;
    endfunction

    function automatic logic pc_black(input logic [3:0] pc);
        logic b;
        case (pc)
            4'd1, 4'd3, 4'd6, 4'd8, 4'd10: b = 1'b1;
            default:                       b = 1'b0;
        endcase
        return b;
    endfunction

    // letter accidentals for a key count; -8 clamps to seven flats
    function automatic t_acc_vec key_state(input logic signed [3:0] count);
        logic signed [3:0] c;
        logic [2:0]        n;
        t_acc_vec          v;
        c = (count == -4'sd8) ? -4'sd7 : count;
        n = c[3] ? 3'(-c) : c[2:0];
        for (int i = 0; i < LETTERS; i++) begin
            v[i] = ACC_NATURAL;
        end
        for (int i = 0; i < LETTERS; i++) begin
            if (3'(i) < n) begin
                if (c[3]) begin
                    v[FLAT_ORDER[i]] = ACC_FLAT;
                end else begin
                    v[SHARP_ORDER[i]] = ACC_SHARP;
                end
            end
        end
        return v;
    endfunction

endpackage

FILE: hw/rtl/midi_note_staff_speller.sv
// Staff speller top level: spells MIDI notes onto staff positions.
// Depends on mnss_pkg and midi_note_staff_speller_macros.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one beat per
//   command. Command note spells i_in_data.note_number; command restore
//   reloads the per-letter accidentals from the key register and gives no
//   output beat.
//   Output channel (o_out_valid / i_out_ready / o_out_data) carries the staff
//   position (octave*7 + letter, C=0..B=6) and the needs-accidental flag.
//   Config: i_cfg_we writes i_cfg_data (signed count, sharps > 0, flats < 0)
//   into the key register; it only takes effect at the next restore.
// Timing:
//   Two register stages (input beat, result beat). A note beat is spelled
//   while it sits in the input stage; its result is registered into the
//   result stage, and o_out_valid is high from then on.
//   One beat per cycle is sustained while no note waits on a stalled output:
//   the accidental table is read and updated while a beat is in the input
//   stage, so the next beat sees the update immediately.
// Reset (synchronous, active low): both stages empty, key register 0, key of
//   C loaded (all natural, sharps preferred).
// Stall: a held output beat blocks the input stage only if that stage holds
//   a note; restore beats drain regardless. Upstream sees o_in_ready drop
//   only when both stages are full and the receiver is stalled.
`include "midi_note_staff_speller_macros.svh"

module midi_note_staff_speller (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic signed [3:0]       i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  mnss_pkg::t_in_beat      i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output mnss_pkg::t_out_beat     o_out_data
);

    logic                 r_in_valid;
    mnss_pkg::t_in_beat   r_in;
    logic                 r_out_valid;
    mnss_pkg::t_out_beat  r_out;
    logic signed [3:0]    r_key;
    mnss_pkg::t_acc_vec   r_acc;
    logic                 r_prefer;

    mnss_pkg::t_acc_vec   n_acc;
    logic                 n_prefer;
    mnss_pkg::t_out_beat  n_out;

    logic        is_restore;
    logic        in_note;
    logic        out_stalled;
    logic        adv;
    logic        note_adv;
    logic        white_adv;
    logic [12:0] recip;
    logic [3:0]  octave;
    logic [6:0]  pc_full;
    logic [3:0]  pc;
    logic [2:0]  letter;
    logic [2:0]  letter_up;
    logic [2:0]  n_letter;
    logic        n_flag;
    logic [mnss_pkg::LETTERS-1:0] acc_natural;

    // --- handshake ---
    assign is_restore  = (r_in.command == mnss_pkg::CMD_RESTORE);
    assign in_note     = r_in_valid && !is_restore;
    assign out_stalled = r_out_valid && !i_out_ready;
    assign adv         = r_in_valid && !(in_note && out_stalled);
    assign note_adv    = adv && !is_restore;
    assign o_in_ready  = !r_in_valid || adv;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // --- note / 12 by reciprocal (43/512 is exact for 0..127) ---
    assign recip     = 13'(r_in.note_number) * 13'd43;
    assign octave    = recip[12:9];
    assign pc_full   = r_in.note_number - 7'({octave, 3'b000}) - 7'({octave, 2'b00});
    assign pc        = pc_full[3:0];
    assign letter    = mnss_pkg::pc_letter(pc);
    assign letter_up = letter + 3'd1;
    assign white_adv = note_adv && !mnss_pkg::pc_black(pc);

    // --- spelling and accidental update ---
    always_comb begin
        n_acc    = r_acc;
        n_prefer = r_prefer;
        n_letter = letter;
        n_flag   = 1'b0;
        if (is_restore) begin
            n_acc    = mnss_pkg::key_state(r_key);
            n_prefer = !r_key[3];
        end else if (!mnss_pkg::pc_black(pc)) begin
            if (r_acc[letter] != mnss_pkg::ACC_NATURAL) begin
                n_acc[letter] = mnss_pkg::ACC_NATURAL;
                n_flag        = 1'b1;
            end
        end else if (r_acc[letter] == mnss_pkg::ACC_SHARP) begin
            n_flag = 1'b0;
        end else if (r_acc[letter_up] == mnss_pkg::ACC_FLAT) begin
            n_letter = letter_up;
        end else if (r_prefer) begin
            n_acc[letter] = mnss_pkg::ACC_SHARP;
            n_flag        = 1'b1;
        end else begin
            n_letter         = letter_up;
            n_acc[letter_up] = mnss_pkg::ACC_FLAT;
            n_flag           = 1'b1;
        end
    end

    // staff = octave*7 + letter
    always_comb begin
        n_out.staff_note       = 7'({octave, 3'b000}) - 7'(octave) + 7'(n_letter);
        n_out.needs_accidental = n_flag;
    end

    // per-letter natural flags for the checks
    always_comb begin
        for (int i = 0; i < mnss_pkg::LETTERS; i++) begin
            acc_natural[i] = (r_acc[i] == mnss_pkg::ACC_NATURAL);
        end
    end

    // --- control state ---
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_key       <= 4'sd0;
            r_acc       <= mnss_pkg::key_state(4'sd0);
            r_prefer    <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_key <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_acc    <= n_acc;
                r_prefer <= n_prefer;
            end
            if (note_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // --- payload ---
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (note_adv) begin
            r_out <= n_out;
        end
    end

    // --- checks ---
    `MNSS_ASSERT_NEXT(a_note_gives_beat, i_clk, i_rst_n, note_adv, r_out_valid)
    `MNSS_ASSERT_NEXT(a_white_goes_natural, i_clk, i_rst_n, white_adv, acc_natural[$past(letter)])
    `MNSS_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n, !o_in_ready, in_note && out_stalled)

endmodule
